>>> rtl/swfl_pkg.sv
// Shared types and constants of the sliding window flood limiter.
package swfl_pkg;

	localparam int unsigned RING_DEPTH_DEF = 32;

	localparam int unsigned LIMIT_W   = 6;
	localparam int unsigned WINDOW_W  = 20;
	localparam int unsigned PENALTY_W = 20;
	localparam int unsigned TIME_W    = 32;
	localparam int unsigned LEFT_W    = 20;
	localparam int unsigned CFG_ADDR_W = 4;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [WINDOW_W-1:0]  WINDOW_RST  = 20'd4000;
	localparam logic [PENALTY_W-1:0] PENALTY_RST = 20'd10000;

	typedef enum logic [1:0] {
		CAUSE_OK    = 2'd0,
		CAUSE_LOCK  = 2'd1,
		CAUSE_FLOOD = 2'd2
	} cause_t;

	typedef enum logic [1:0] {
		REG_GENERAL_LIMIT = 2'd0,
		REG_TEAM_LIMIT    = 2'd1,
		REG_WINDOW        = 2'd2,
		REG_PENALTY       = 2'd3
	} reg_idx_t;

endpackage

>>> rtl/swfl_if.sv
// Event and verdict channel interfaces of the sliding window flood limiter.
interface swfl_evt_if;
	import swfl_pkg::*;
	logic              valid;
	logic              ready;
	logic              mode;
	logic [TIME_W-1:0] now_ms;

	modport source (output valid, mode, now_ms, input ready);
	modport sink (input valid, mode, now_ms, output ready);
endinterface

interface swfl_res_if;
	import swfl_pkg::*;
	logic              valid;
	logic              ready;
	logic              blocked;
	cause_t            cause;
	logic [LEFT_W-1:0] lock_left_ms;

	modport source (output valid, blocked, cause, lock_left_ms, input ready);
	modport sink (input valid, blocked, cause, lock_left_ms, output ready);
endinterface

>>> rtl/sliding_window_flood_limiter_top.sv
// Sliding window flood limiter: per-source message rate limiter with lockout.
//
// Each word on evt carries a message class (mode: 0 general, 1 team) and the
// current time in milliseconds. For every accepted word exactly one verdict
// word leaves on res: blocked, cause (accepted, lockout active, flood now)
// and the remaining lockout time. Both channels use valid/ready.
// The APB port holds the limits, the window and the penalty; write it only
// while no word is in flight.
// An accepted word waits in the working stage; its verdict is registered in the
// output register as it leaves. Throughput is one word per cycle while res is not
// stalled: the stamp ring is a memory read at accept time on two ports (the slot for
// the current head and for the head one step ahead), so the verdict of the word in
// front only picks between the two and never waits on a memory access.
// When res stalls, the verdict waits in the output register and one more
// word is taken into the working stage, then evt.ready drops.
// Reset clears the heads, the lockout and the fill counts of both rings at
// once; a slot not yet written reads as empty, so no clearing pass is run.
module sliding_window_flood_limiter_top #(
	parameter int unsigned RING_DEPTH = swfl_pkg::RING_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	swfl_evt_if.sink                        evt,
	swfl_res_if.source                      res,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [swfl_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [swfl_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [swfl_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready
);
	import swfl_pkg::*;

	localparam int unsigned IDX_W  = $clog2(RING_DEPTH);
	localparam int unsigned FILL_W = $clog2(RING_DEPTH + 1);
	localparam int unsigned CALC_W = (IDX_W + 2 > LIMIT_W + 1) ? IDX_W + 2 : LIMIT_W + 1;
	localparam int unsigned MEM_DEPTH = 2 ** (IDX_W + 1);
	localparam logic [CALC_W-1:0] DEPTH_C  = CALC_W'(RING_DEPTH);
	localparam logic [CALC_W-1:0] ONE_C    = CALC_W'(1);
	localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(RING_DEPTH - 1);
	localparam logic [FILL_W-1:0] DEPTH_F  = FILL_W'(RING_DEPTH);

	// Configuration registers
	logic [LIMIT_W-1:0]   gen_limit_q;
	logic [LIMIT_W-1:0]   team_limit_q;
	logic [WINDOW_W-1:0]  window_q;
	logic [PENALTY_W-1:0] penalty_q;
	reg_idx_t             cfg_idx;

	assign cfg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_limit_q  <= '0;
			team_limit_q <= '0;
			window_q     <= WINDOW_RST;
			penalty_q    <= PENALTY_RST;
		end else if (psel && penable && pwrite) begin
			unique case (cfg_idx)
				REG_GENERAL_LIMIT: gen_limit_q  <= pwdata[LIMIT_W-1:0];
				REG_TEAM_LIMIT:    team_limit_q <= pwdata[LIMIT_W-1:0];
				REG_WINDOW:        window_q     <= pwdata[WINDOW_W-1:0];
				REG_PENALTY:       penalty_q    <= pwdata[PENALTY_W-1:0];
				default:           ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_GENERAL_LIMIT: prdata = CFG_DATA_W'(gen_limit_q);
			REG_TEAM_LIMIT:    prdata = CFG_DATA_W'(team_limit_q);
			REG_WINDOW:        prdata = CFG_DATA_W'(window_q);
			REG_PENALTY:       prdata = CFG_DATA_W'(penalty_q);
			default:           prdata = '0;
		endcase
	end

	// Ring state: both rings share one memory, the class bit on top of the address.
	logic [TIME_W-1:0] stamp_mem [MEM_DEPTH];
	logic [IDX_W-1:0]  head_q [2];
	logic [FILL_W-1:0] fill_q [2];
	logic [TIME_W-1:0] lock_q;

	// Working stage
	logic              s1_valid_q;
	logic              mode_s1;
	logic [TIME_W-1:0] now_s1;
	logic [TIME_W-1:0] rd_a_s1;
	logic [TIME_W-1:0] rd_b_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              take_b_s1;
	logic              byp_s1;
	logic [TIME_W-1:0] byp_now_s1;

	// Output register
	logic              res_valid_q;
	logic              blocked_q;
	cause_t            cause_q;
	logic [LEFT_W-1:0] left_q;

	logic s1_adv;
	logic s1_accept;
	logic evt_fire;

	assign s1_adv   = s1_valid_q && (!res_valid_q || res.ready);
	assign evt.ready = !s1_valid_q || s1_adv;
	assign evt_fire = evt.valid && evt.ready;

	// Read addresses for the incoming word
	logic [LIMIT_W-1:0] evt_limit;
	logic [CALC_W-1:0]  evt_lim;
	logic [IDX_W-1:0]   evt_head;
	logic [CALC_W-1:0]  addr_sum;
	logic [IDX_W-1:0]   addr_a;
	logic [IDX_W-1:0]   addr_b;
	logic               take_b;
	logic               bypass;

	always_comb begin
		evt_limit = evt.mode ? team_limit_q : gen_limit_q;
		if (CALC_W'(evt_limit) > DEPTH_C) begin
			evt_lim = DEPTH_C;
		end else if (evt_limit == '0) begin
			evt_lim = ONE_C;
		end else begin
			evt_lim = CALC_W'(evt_limit);
		end
		evt_head = evt.mode ? head_q[1] : head_q[0];
		addr_sum = CALC_W'(evt_head) + DEPTH_C - evt_lim + ONE_C;
		if (addr_sum >= DEPTH_C) begin
			addr_a = IDX_W'(addr_sum - DEPTH_C);
		end else begin
			addr_a = IDX_W'(addr_sum);
		end
		addr_b = (addr_a == LAST_IDX) ? '0 : addr_a + IDX_W'(1);
		// The word in front records into the same ring at this edge: its head moves on.
		take_b = s1_valid_q && s1_adv && s1_accept && (mode_s1 == evt.mode);
		// With a limit of one the slot to read is the one being written right now.
		bypass = take_b && (evt_lim == ONE_C);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (evt_fire) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	// Verdict of the word in the working stage
	logic              lock_applies;
	logic              locked;
	logic              flood;
	logic [LIMIT_W-1:0] s1_limit;
	logic [TIME_W-1:0] stamp;
	logic [FILL_W-1:0] fill_sel;
	logic              slot_ok;
	logic [TIME_W:0]   win_end;
	logic [TIME_W:0]   lock_end_w;
	logic [TIME_W-1:0] lock_end;
	logic [TIME_W-1:0] left_diff;
	logic [IDX_W-1:0]  cur_head;
	logic [IDX_W-1:0]  head_next;

	always_comb begin
		s1_limit     = mode_s1 ? team_limit_q : gen_limit_q;
		lock_applies = !mode_s1 || (team_limit_q != '0);
		locked       = lock_applies && (now_s1 < lock_q);
		if (byp_s1) begin
			stamp = byp_now_s1;
		end else if (take_b_s1) begin
			stamp = rd_b_s1;
		end else begin
			stamp = rd_a_s1;
		end
		fill_sel = mode_s1 ? fill_q[1] : fill_q[0];
		slot_ok  = (fill_sel == DEPTH_F) || ((idx_s1 != '0) && (FILL_W'(idx_s1) <= fill_sel));
		win_end  = {1'b0, stamp} + (TIME_W + 1)'(window_q);
		flood    = (s1_limit != '0) && (penalty_q != '0) && slot_ok && (stamp != '0) &&
			(stamp <= now_s1) && ({1'b0, now_s1} < win_end);
		lock_end_w = {1'b0, now_s1} + (TIME_W + 1)'(penalty_q);
		lock_end   = lock_end_w[TIME_W] ? '1 : lock_end_w[TIME_W-1:0];
		left_diff  = (locked ? lock_q : lock_end) - now_s1;
		s1_accept  = !locked && !flood;
		cur_head   = mode_s1 ? head_q[1] : head_q[0];
		head_next  = (cur_head == LAST_IDX) ? '0 : cur_head + IDX_W'(1);
	end

	// Memory and working-stage payload
	always_ff @(posedge clk) begin
		if (s1_adv && s1_accept) begin
			stamp_mem[{mode_s1, head_next}] <= now_s1;
		end
		if (evt_fire) begin
			mode_s1    <= evt.mode;
			now_s1     <= evt.now_ms;
			rd_a_s1    <= stamp_mem[{evt.mode, addr_a}];
			rd_b_s1    <= stamp_mem[{evt.mode, addr_b}];
			idx_s1     <= take_b ? addr_b : addr_a;
			take_b_s1  <= take_b;
			byp_s1     <= bypass;
			byp_now_s1 <= now_s1;
		end
	end

	// State update as the word leaves the working stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q[0] <= '0;
			head_q[1] <= '0;
			fill_q[0] <= '0;
			fill_q[1] <= '0;
			lock_q    <= '0;
		end else if (s1_adv) begin
			if (flood && !locked) begin
				lock_q <= lock_end;
			end
			if (s1_accept) begin
				head_q[mode_s1] <= head_next;
				if (fill_sel != DEPTH_F) begin
					fill_q[mode_s1] <= fill_sel + FILL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_adv) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			blocked_q <= !s1_accept;
			if (locked) begin
				cause_q <= CAUSE_LOCK;
			end else if (flood) begin
				cause_q <= CAUSE_FLOOD;
			end else begin
				cause_q <= CAUSE_OK;
			end
			left_q <= s1_accept ? '0 : left_diff[LEFT_W-1:0];
		end
	end

	assign res.valid        = res_valid_q;
	assign res.blocked      = blocked_q;
	assign res.cause        = cause_q;
	assign res.lock_left_ms = left_q;

	// Checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q[0] <= DEPTH_F) && (fill_q[1] <= DEPTH_F))
		else $error("ring fill count beyond ring depth");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(now_s1) && $stable(mode_s1)))
		else $error("stalled word lost from working stage");

	a_verdict_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> ((res.blocked == (res.cause != CAUSE_OK)) &&
			(res.blocked || (res.lock_left_ms == '0))))
		else $error("verdict fields disagree");

	a_flood_locks: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && flood && !locked) |=> (lock_q == $past(lock_end)))
		else $error("flood did not set the lockout");

endmodule

>>> test/sliding_window_flood_limiter_top_tb.sv
// Self-checking testbench of the sliding window flood limiter top level.
`timescale 1ns / 100ps

module sliding_window_flood_limiter_top_tb;
	import swfl_pkg::*;

	localparam int unsigned RING_DEPTH = RING_DEPTH_DEF;
	localparam int unsigned NUM_PHASES = 8;
	localparam int unsigned PHASE_MSGS = 119;

	typedef struct packed {
		logic              mode;
		logic [TIME_W-1:0] now_ms;
	} msg_t;

	typedef struct packed {
		logic              blocked;
		cause_t            cause;
		logic [LEFT_W-1:0] lock_left_ms;
	} verdict_t;

	// Limits, window and penalty of each random phase, in register order.
	int unsigned phase_cfg [NUM_PHASES][4] = '{
		'{4, 2, 1000, 5000},
		'{1, 1, 1, 3},
		'{32, 32, 1000000, 1000000},
		'{0, 5, 2000, 700},
		'{8, 0, 3000, 0},
		'{16, 3, 500, 250},
		'{2, 32, 100, 20000},
		'{5, 7, 4000, 10000}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic pready;

	swfl_evt_if evt_ch ();
	swfl_res_if res_ch ();

	sliding_window_flood_limiter_top #(
		.RING_DEPTH(RING_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.evt(evt_ch),
		.res(res_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	// Shadow copy of the limiter state and its settings.
	logic [LIMIT_W-1:0]   gen_cap;
	logic [LIMIT_W-1:0]   team_cap;
	logic [WINDOW_W-1:0]  window_len;
	logic [PENALTY_W-1:0] penalty_len;
	logic [TIME_W-1:0]    gen_stamps [RING_DEPTH];
	logic [TIME_W-1:0]    team_stamps [RING_DEPTH];
	int unsigned          gen_slot;
	int unsigned          team_slot;
	logic [TIME_W-1:0]    locked_until;

	msg_t     msgs_to_send [$];
	verdict_t verdicts_due [$];

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	logic        rx_hold;
	int unsigned errors;
	int unsigned n_accepted;
	int unsigned n_team;
	int unsigned n_ok;
	int unsigned n_lock;
	int unsigned n_flood;
	int unsigned n_reg_writes;
	logic [TIME_W-1:0] clock_ms;

	function automatic verdict_t judge_message(msg_t m);
		verdict_t v;
		logic [LIMIT_W-1:0] cap;
		int unsigned cap_sat;
		int unsigned slot;
		int unsigned idx;
		logic [TIME_W-1:0] stamp;
		logic [TIME_W:0] lock_end;
		logic flood;
		v.blocked = 1'b0;
		v.cause = CAUSE_OK;
		v.lock_left_ms = '0;
		cap = m.mode ? team_cap : gen_cap;
		slot = m.mode ? team_slot : gen_slot;
		// Team messages only honor the lockout while a team limit is set.
		if ((!m.mode || team_cap != 0) && m.now_ms < locked_until) begin
			v.blocked = 1'b1;
			v.cause = CAUSE_LOCK;
			v.lock_left_ms = LEFT_W'(locked_until - m.now_ms);
		end else begin
			cap_sat = (cap > RING_DEPTH) ? RING_DEPTH : cap;
			idx = (slot + RING_DEPTH - cap_sat + 1) % RING_DEPTH;
			stamp = m.mode ? team_stamps[idx] : gen_stamps[idx];
			flood = cap != 0 && penalty_len != 0 && stamp != 0 && stamp <= m.now_ms &&
				{1'b0, m.now_ms} < {1'b0, stamp} + (TIME_W+1)'(window_len);
			if (flood) begin
				lock_end = {1'b0, m.now_ms} + (TIME_W+1)'(penalty_len);
				locked_until = lock_end[TIME_W] ? '1 : lock_end[TIME_W-1:0];
				v.blocked = 1'b1;
				v.cause = CAUSE_FLOOD;
				v.lock_left_ms = LEFT_W'(locked_until - m.now_ms);
			end else begin
				slot = (slot + 1) % RING_DEPTH;
				if (m.mode) begin
					team_slot = slot;
					team_stamps[slot] = m.now_ms;
				end else begin
					gen_slot = slot;
					gen_stamps[slot] = m.now_ms;
				end
			end
		end
		return v;
	endfunction

	task automatic check_reg(reg_idx_t r, logic [CFG_DATA_W-1:0] want);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {r, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if (prdata !== want) begin
			$display("%0t: register %s reads wrong: expected %0d, actual %0d",
				$time, r.name(), want, prdata);
			errors++;
		end
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_reg(reg_idx_t r, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (r)
			REG_GENERAL_LIMIT: gen_cap = val[LIMIT_W-1:0];
			REG_TEAM_LIMIT:    team_cap = val[LIMIT_W-1:0];
			REG_WINDOW:        window_len = val[WINDOW_W-1:0];
			REG_PENALTY:       penalty_len = val[PENALTY_W-1:0];
			default: ;
		endcase
		n_reg_writes++;
		check_reg(r, val);
	endtask

	task automatic program_limits(int unsigned g, int unsigned t, int unsigned w,
		int unsigned p);
		set_reg(REG_GENERAL_LIMIT, g);
		set_reg(REG_TEAM_LIMIT, t);
		set_reg(REG_WINDOW, w);
		set_reg(REG_PENALTY, p);
	endtask

	task automatic wait_idle();
		while (msgs_to_send.size() != 0 || verdicts_due.size() != 0 || evt_ch.valid)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic push_msg(logic mode, logic [TIME_W-1:0] now_ms);
		msg_t m;
		m.mode = mode;
		m.now_ms = now_ms;
		msgs_to_send.push_back(m);
	endtask

	// Mostly a running clock paced around the window per allowed message, so that
	// floods and lockouts both happen; a few stray timestamps anywhere in range.
	task automatic load_random(int unsigned count);
		int unsigned r;
		int unsigned span;
		msg_t m;
		span = 32'(gen_cap > team_cap ? gen_cap : team_cap);
		span = (span == 0) ? window_len : 2 * window_len / span;
		repeat (count) begin
			r = $urandom_range(0, 99);
			m.mode = 1'($urandom_range(0, 1));
			if (r < 3) begin
				m.now_ms = $urandom;
			end else begin
				if (r < 70)
					clock_ms += $urandom_range(0, span);
				else if (r < 85)
					clock_ms += $urandom_range(0, penalty_len / 2 + 1);
				else if (r >= 92)
					clock_ms += $urandom_range(1, 3);
				m.now_ms = clock_ms;
			end
			msgs_to_send.push_back(m);
		end
	endtask

	// Sender: offers one word at a time and predicts its verdict once accepted.
	always @(posedge clk) begin : drive_proc
		msg_t m;
		if (arst_n) begin
			if (evt_ch.valid && evt_ch.ready) begin
				m.mode = evt_ch.mode;
				m.now_ms = evt_ch.now_ms;
				verdicts_due.push_back(judge_message(m));
				n_accepted++;
				if (m.mode)
					n_team++;
			end
			if (evt_ch.valid && !evt_ch.ready) begin
				// Word not taken yet: keep it on the bus.
			end else if (msgs_to_send.size() != 0 &&
				$urandom_range(0, 99) >= send_idle_pct) begin
				m = msgs_to_send.pop_front();
				evt_ch.valid <= 1'b1;
				evt_ch.mode <= m.mode;
				evt_ch.now_ms <= m.now_ms;
			end else begin
				evt_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver: checks every verdict word against the oldest prediction.
	always @(posedge clk) begin : watch_proc
		verdict_t want;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				if (verdicts_due.size() == 0) begin
					$display("%0t: verdict with none expected: blocked %0d cause %0d left %0d",
						$time, res_ch.blocked, res_ch.cause, res_ch.lock_left_ms);
					errors++;
				end else begin
					want = verdicts_due.pop_front();
					if (res_ch.blocked !== want.blocked) begin
						$display("%0t: blocked: expected %0d, actual %0d",
							$time, want.blocked, res_ch.blocked);
						errors++;
					end
					if (res_ch.cause !== want.cause) begin
						$display("%0t: cause: expected %0d, actual %0d",
							$time, want.cause, res_ch.cause);
						errors++;
					end
					if (res_ch.lock_left_ms !== want.lock_left_ms) begin
						$display("%0t: lock_left_ms: expected %0d, actual %0d",
							$time, want.lock_left_ms, res_ch.lock_left_ms);
						errors++;
					end
					case (want.cause)
						CAUSE_OK:    n_ok++;
						CAUSE_LOCK:  n_lock++;
						CAUSE_FLOOD: n_flood++;
						default: ;
					endcase
				end
			end
			res_ch.ready <= !rx_hold && ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Long receiver stall while the sender keeps offering, to fill the block.
	initial begin : hold_proc
		rx_hold = 1'b0;
		wait (n_accepted >= 760);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (300) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin : limit_proc
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stim_proc
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		evt_ch.valid = 1'b0;
		evt_ch.mode = 1'b0;
		evt_ch.now_ms = '0;
		res_ch.ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		errors = 0;
		n_accepted = 0;
		n_team = 0;
		n_ok = 0;
		n_lock = 0;
		n_flood = 0;
		n_reg_writes = 0;
		gen_cap = '0;
		team_cap = '0;
		window_len = WINDOW_RST;
		penalty_len = PENALTY_RST;
		for (int k = 0; k < RING_DEPTH; k++) begin
			gen_stamps[k] = '0;
			team_stamps[k] = '0;
		end
		gen_slot = 0;
		team_slot = 0;
		locked_until = '0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		check_reg(REG_GENERAL_LIMIT, 0);
		check_reg(REG_TEAM_LIMIT, 0);
		check_reg(REG_WINDOW, 32'(WINDOW_RST));
		check_reg(REG_PENALTY, 32'(PENALTY_RST));

		// One general message per window; stamps of zero count as empty slots.
		program_limits(1, 2, 1000, 5000);
		push_msg(1'b0, 0);
		push_msg(1'b0, 0);
		push_msg(1'b0, 10);
		push_msg(1'b0, 20);
		push_msg(1'b0, 30);
		push_msg(1'b1, 40);
		wait_idle();

		// Without a team limit, team messages pass through the running lockout.
		set_reg(REG_TEAM_LIMIT, 0);
		push_msg(1'b1, 50);
		push_msg(1'b1, 60);
		push_msg(1'b1, 70);
		push_msg(1'b1, 32'hFFFF_FFFF);
		push_msg(1'b0, 5019);
		push_msg(1'b0, 5020);
		wait_idle();

		// A zero penalty turns the check off.
		program_limits(3, 2, 1000, 0);
		repeat (4) push_msg(1'b0, 6000);
		wait_idle();

		clock_ms = 7000;
		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p < 3) begin
				send_idle_pct = 6;
				recv_stall_pct = 65;
			end else if (p < 6) begin
				send_idle_pct = 65;
				recv_stall_pct = 6;
			end else begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			program_limits(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2],
				phase_cfg[p][3]);
			// The last phase runs near the top of the time range.
			if (p == NUM_PHASES - 1)
				clock_ms = 32'hFF00_0000;
			load_random(PHASE_MSGS);
			wait_idle();
		end

		// Lockout end saturates at the largest time.
		program_limits(1, 1, 1000000, 1000000);
		push_msg(1'b0, 32'hFFFF_FF00);
		push_msg(1'b0, 32'hFFFF_FF01);
		push_msg(1'b0, 32'hFFFF_FFFE);
		push_msg(1'b1, 32'hFFFF_FF10);
		push_msg(1'b0, 32'hFFFF_FFFF);
		wait_idle();

		repeat (10) @(posedge clk);
		if (verdicts_due.size() != 0) begin
			$display("%0t: %0d verdicts never arrived", $time, verdicts_due.size());
			errors++;
		end
		$display("Sent %0d messages (%0d team) over %0d register writes.",
			n_accepted, n_team, n_reg_writes);
		$display("Verdicts: %0d accepted, %0d under lockout, %0d floods.",
			n_ok, n_lock, n_flood);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/swfl_pkg.sv
rtl/swfl_if.sv
rtl/sliding_window_flood_limiter_top.sv
test/sliding_window_flood_limiter_top_tb.sv
